FILE: rtl/sha256_block_compress_unit_macros.svh
// Assertion macros shared by the SHA-256 compression RTL.
`ifndef SHA256_BLOCK_COMPRESS_UNIT_MACROS_SVH
`define SHA256_BLOCK_COMPRESS_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SBC_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sbc assertion failed");

// Next-cycle implication, disabled during reset.
`define SBC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sbc assertion failed");

`endif

FILE: rtl/sbc_pkg.sv
// Types, constants and round functions of the SHA-256 compression unit.
package sbc_pkg;

    typedef logic [31:0]      word_t;
    typedef logic [7:0][31:0] chain_t;
    typedef logic [1:0]       op_t;
    typedef logic [5:0]       round_t;

    typedef struct packed {
        logic push;
        logic start;
        logic step;
    } sbc_ctrl_t;

    localparam op_t OP_MSG_WORD   = 2'd0;
    localparam op_t OP_LOAD_CHAIN = 2'd1;
    localparam op_t OP_RESTORE_IV = 2'd2;

    localparam round_t ROUND_LAST = 6'd63;

    localparam chain_t INIT_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t rotr(input word_t v, input int unsigned n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    function automatic word_t big_sigma0(input word_t v);
        big_sigma0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t v);
        big_sigma1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
    endfunction

    function automatic word_t small_sigma0(input word_t v);
        small_sigma0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t v);
        small_sigma1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
    endfunction

endpackage

FILE: rtl/sbc_schedule.sv
// Rolling 16-word message schedule window of the SHA-256 compression unit.
module sbc_schedule (
    input  logic              aclk,
    input  sbc_pkg::sbc_ctrl_t ctrl,
    input  sbc_pkg::word_t    msg_word,
    output sbc_pkg::word_t    wt
);
    import sbc_pkg::*;

    word_t window_reg [16];
    word_t expand_next;

    always_comb begin
        expand_next = small_sigma1(window_reg[14]) + window_reg[9]
                    + small_sigma0(window_reg[1]) + window_reg[0];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.push || ctrl.step) begin
            for (int i = 0; i < 15; i++) begin
                window_reg[i] <= window_reg[i + 1];
            end
            window_reg[15] <= ctrl.push ? msg_word : expand_next;
        end
    end

    assign wt = window_reg[0];

endmodule

FILE: rtl/sbc_round.sv
// Working variables and one-round-per-cycle datapath of the SHA-256 compression unit.
module sbc_round (
    input  logic               aclk,
    input  sbc_pkg::sbc_ctrl_t ctrl,
    input  sbc_pkg::chain_t    chain_in,
    input  sbc_pkg::word_t     wt,
    input  sbc_pkg::word_t     kt,
    output sbc_pkg::chain_t    wv
);
    import sbc_pkg::*;

    chain_t wv_reg;
    chain_t wv_next;
    word_t  t1;
    word_t  t2;
    word_t  ch;
    word_t  maj;

    always_comb begin
        ch  = (wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]);
        maj = (wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2]) ^ (wv_reg[1] & wv_reg[2]);
        t1  = wv_reg[7] + big_sigma1(wv_reg[4]) + ch + kt + wt;
        t2  = big_sigma0(wv_reg[0]) + maj;
        wv_next[7] = wv_reg[6];
        wv_next[6] = wv_reg[5];
        wv_next[5] = wv_reg[4];
        wv_next[4] = wv_reg[3] + t1;
        wv_next[3] = wv_reg[2];
        wv_next[2] = wv_reg[1];
        wv_next[1] = wv_reg[0];
        wv_next[0] = t1 + t2;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            wv_reg <= chain_in;
        end else if (ctrl.step) begin
            wv_reg <= wv_next;
        end
    end

    assign wv = wv_reg;

endmodule

FILE: rtl/sha256_block_compress_unit.sv
// Top level of the SHA-256 block compression unit: sequencer, chaining value, output register.
//
// Input channel (s_valid/s_ready): one transaction per op. op 0 pushes a
// message word, op 1 loads chain word s_index with s_word, op 2 restores the
// initial hash value and drops a partly loaded block; op 3 is ignored.
// Output channel (m_valid/m_ready): after the sixteenth message word the
// unit emits the eight updated chain words in order, m_last on word 7.
// Sequence: the sixteenth word starts 64 rounds on a single round datapath
// (one round per cycle), then the eight chain words are added and emitted
// one per cycle while the receiver is ready, through one shared adder.
// s_ready is low from the sixteenth word until the last result is loaded
// into the output register; an unloaded result stays in that register while
// new input transactions are taken. A stalled receiver (m_ready low) holds
// the output register and pauses emission. Reset (aresetn low, synchronous)
// restores the initial hash value, clears the word count and drops any
// pending result.
module sha256_block_compress_unit (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  sbc_pkg::op_t    s_op,
    input  sbc_pkg::word_t  s_word,
    input  logic [2:0]      s_index,
    output logic            m_valid,
    input  logic            m_ready,
    output sbc_pkg::word_t  m_digest_word,
    output logic [2:0]      m_word_index,
    output logic            m_last
);
    import sbc_pkg::*;
    `include "sha256_block_compress_unit_macros.svh"

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic [3:0] words_loaded_reg;
    round_t     round_reg;
    logic [2:0] emit_idx_reg;
    chain_t     chain_reg;
    logic       m_valid_reg;
    word_t      m_word_reg;
    logic [2:0] m_index_reg;
    logic       m_last_reg;

    sbc_ctrl_t ctrl;
    word_t     wt;
    chain_t    wv;
    word_t     sum;
    logic      in_fire;
    logic      out_free;
    logic      emit_fire;
    logic      in_emit;
    logic      last_round;

    assign s_ready    = (state_reg == ST_IDLE);
    assign in_fire    = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign in_emit    = (state_reg == ST_EMIT);
    assign emit_fire  = in_emit && out_free;
    assign last_round = ctrl.step && (round_reg == ROUND_LAST);
    assign sum        = chain_reg[emit_idx_reg] + wv[emit_idx_reg];

    always_comb begin
        ctrl.push  = in_fire && (s_op == OP_MSG_WORD);
        ctrl.start = ctrl.push && (words_loaded_reg == 4'd15);
        ctrl.step  = (state_reg == ST_ROUND);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (ctrl.start) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (last_round) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_fire && (emit_idx_reg == 3'd7)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    sbc_schedule u_schedule (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .msg_word (s_word),
        .wt       (wt)
    );

    sbc_round u_round (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .chain_in (chain_reg),
        .wt       (wt),
        .kt       (ROUND_K[round_reg]),
        .wv       (wv)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            words_loaded_reg <= '0;
            round_reg        <= '0;
            emit_idx_reg     <= '0;
            chain_reg        <= INIT_HASH;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (in_fire) begin
                case (s_op)
                    OP_MSG_WORD:   words_loaded_reg <= words_loaded_reg + 4'd1;
                    OP_LOAD_CHAIN: chain_reg[s_index] <= s_word;
                    OP_RESTORE_IV: begin
                        chain_reg        <= INIT_HASH;
                        words_loaded_reg <= '0;
                    end
                    default: ;
                endcase
            end
            if (ctrl.step) begin
                round_reg <= round_reg + 6'd1;
            end
            if (emit_fire) begin
                chain_reg[emit_idx_reg] <= sum;
                emit_idx_reg            <= emit_idx_reg + 3'd1;
                m_valid_reg             <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            m_word_reg  <= sum;
            m_index_reg <= emit_idx_reg;
            m_last_reg  <= (emit_idx_reg == 3'd7);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_digest_word = m_word_reg;
    assign m_word_index  = m_index_reg;
    assign m_last        = m_last_reg;

    `SBC_ASSERT_NEXT(a_block_starts, aclk, aresetn, ctrl.start, ctrl.step && (round_reg == 6'd0))
    `SBC_ASSERT_NEXT(a_rounds_end, aclk, aresetn, last_round, in_emit && (emit_idx_reg == 3'd0))
    `SBC_ASSERT_IMPLY(a_busy_count_clear, aclk, aresetn, !s_ready, words_loaded_reg == 4'd0)

endmodule

FILE: test/sha256_block_compress_checker.sv
// Watches both channels of the SHA-256 compression unit, predicts digest words, flags mismatches.
module sha256_block_compress_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  sbc_pkg::op_t        s_op,
    input  sbc_pkg::word_t      s_word,
    input  logic [2:0]          s_index,
    input  logic                m_valid,
    input  logic                m_ready,
    input  sbc_pkg::word_t      m_digest_word,
    input  logic [2:0]          m_word_index,
    input  logic                m_last,
    output int unsigned         fail_count,
    output int unsigned         pending,
    output int unsigned         digests_checked
);
    import sbc_pkg::*;

    typedef struct {
        word_t      value;
        logic [2:0] pos;
        logic       last;
    } digest_entry_t;

    localparam word_t ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam word_t START_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    word_t         chain_words [8];
    word_t         block_words [16];
    int unsigned   block_fill;
    digest_entry_t digest_expected [$];

    function automatic word_t ror32(input word_t v, input int unsigned n);
        logic [63:0] both;
        both = {v, v} >> n;
        return both[31:0];
    endfunction

    task automatic compress_and_queue();
        word_t sched [64];
        word_t va, vb, vc, vd, ve, vf, vg, vh;
        word_t t1, t2, s0, s1;
        digest_entry_t entry;
        for (int t = 0; t < 64; t++) begin
            if (t < 16) begin
                sched[t] = block_words[t];
            end else begin
                s0 = ror32(sched[t-15], 7) ^ ror32(sched[t-15], 18) ^ (sched[t-15] >> 3);
                s1 = ror32(sched[t-2], 17) ^ ror32(sched[t-2], 19) ^ (sched[t-2] >> 10);
                sched[t] = s1 + sched[t-7] + s0 + sched[t-16];
            end
        end
        va = chain_words[0]; vb = chain_words[1]; vc = chain_words[2]; vd = chain_words[3];
        ve = chain_words[4]; vf = chain_words[5]; vg = chain_words[6]; vh = chain_words[7];
        for (int t = 0; t < 64; t++) begin
            t1 = vh + (ror32(ve, 6) ^ ror32(ve, 11) ^ ror32(ve, 25))
               + ((ve & vf) ^ (~ve & vg)) + ROUND_CONST[t] + sched[t];
            t2 = (ror32(va, 2) ^ ror32(va, 13) ^ ror32(va, 22))
               + ((va & vb) ^ (va & vc) ^ (vb & vc));
            vh = vg; vg = vf; vf = ve; ve = vd + t1;
            vd = vc; vc = vb; vb = va; va = t1 + t2;
        end
        chain_words[0] += va; chain_words[1] += vb; chain_words[2] += vc; chain_words[3] += vd;
        chain_words[4] += ve; chain_words[5] += vf; chain_words[6] += vg; chain_words[7] += vh;
        for (int i = 0; i < 8; i++) begin
            entry.value = chain_words[i];
            entry.pos   = 3'(i);
            entry.last  = (i == 7);
            digest_expected.push_back(entry);
        end
    endtask

    task automatic absorb_transaction(input op_t op, input word_t w, input logic [2:0] idx);
        case (op)
            OP_MSG_WORD: begin
                block_words[block_fill] = w;
                block_fill++;
                if (block_fill == 16) begin
                    block_fill = 0;
                    compress_and_queue();
                end
            end
            OP_LOAD_CHAIN: begin
                chain_words[idx] = w;
            end
            OP_RESTORE_IV: begin
                chain_words = START_HASH;
                block_fill  = 0;
            end
            default: begin
            end
        endcase
    endtask

    task automatic match_digest();
        digest_entry_t want;
        if (digest_expected.size() == 0) begin
            $display("%0t: unexpected digest word %h index %0d last %b",
                     $time, m_digest_word, m_word_index, m_last);
            fail_count++;
        end else begin
            want = digest_expected.pop_front();
            if (m_digest_word !== want.value) begin
                $display("%0t: digest_word expected %h actual %h",
                         $time, want.value, m_digest_word);
                fail_count++;
            end
            if (m_word_index !== want.pos) begin
                $display("%0t: word_index expected %0d actual %0d",
                         $time, want.pos, m_word_index);
                fail_count++;
            end
            if (m_last !== want.last) begin
                $display("%0t: last expected %b actual %b", $time, want.last, m_last);
                fail_count++;
            end
        end
        digests_checked++;
    endtask

    initial begin
        fail_count      = 0;
        pending         = 0;
        digests_checked = 0;
        chain_words     = START_HASH;
        block_fill      = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            chain_words = START_HASH;
            block_fill  = 0;
            digest_expected.delete();
        end else begin
            if (m_valid === 1'b1 && m_ready === 1'b1) begin
                match_digest();
            end
            if (s_valid === 1'b1 && s_ready === 1'b1) begin
                absorb_transaction(s_op, s_word, s_index);
            end
        end
        pending = digest_expected.size();
    end

endmodule

FILE: test/sha256_block_compress_unit_tb.sv
// Top of the SHA-256 compression unit testbench: clock, reset, stimulus and verdict.
module sha256_block_compress_unit_tb;
    import sbc_pkg::*;

    localparam op_t         OP_UNUSED   = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned ITEMS_PHASE = 56;

    logic           aclk    = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    op_t            s_op    = OP_MSG_WORD;
    word_t          s_word  = '0;
    logic [2:0]     s_index = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    word_t          m_digest_word;
    logic [2:0]     m_word_index;
    logic           m_last;

    int unsigned    fail_count;
    int unsigned    pending;
    int unsigned    digests_checked;
    int unsigned    cycles      = 0;
    int unsigned    items_sent  = 0;
    int unsigned    blocks_sent = 0;
    int unsigned    send_idle   = 0;
    int unsigned    recv_idle   = 0;

    sha256_block_compress_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_word        (s_word),
        .s_index       (s_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_last        (m_last)
    );

    sha256_block_compress_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_word          (s_word),
        .s_index         (s_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_digest_word   (m_digest_word),
        .m_word_index    (m_word_index),
        .m_last          (m_last),
        .fail_count      (fail_count),
        .pending         (pending),
        .digests_checked (digests_checked)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Timeout after %0d cycles", cycles);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic word_t pick_word();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel == 0) begin
            return '0;
        end else if (sel == 1) begin
            return '1;
        end
        return $urandom;
    endfunction

    task automatic push_transaction(input op_t op, input word_t w, input logic [2:0] idx);
        while ($urandom_range(99) < send_idle) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_op    = op;
        s_word  = w;
        s_index = idx;
        s_valid = 1'b1;
        do @(posedge aclk); while (s_ready !== 1'b1);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic push_block(input int unsigned words, input bit with_loads);
        for (int i = 0; i < words; i++) begin
            if (with_loads && $urandom_range(15) == 0) begin
                push_transaction(OP_LOAD_CHAIN, pick_word(), 3'($urandom));
            end
            push_transaction(OP_MSG_WORD, pick_word(), 3'($urandom));
        end
    endtask

    task automatic random_phase(input int unsigned target);
        int unsigned start_count;
        int unsigned choice;
        start_count = items_sent;
        while (items_sent - start_count < target) begin
            choice = $urandom_range(99);
            if (choice < 70) begin
                push_block(16, 1'b1);
                blocks_sent++;
            end else if (choice < 80) begin
                push_block($urandom_range(15, 1), 1'b1);
                push_transaction(OP_RESTORE_IV, pick_word(), 3'($urandom));
            end else if (choice < 90) begin
                repeat ($urandom_range(8, 1)) begin
                    push_transaction(OP_LOAD_CHAIN, pick_word(), 3'($urandom));
                end
            end else if (choice < 95) begin
                push_transaction(OP_RESTORE_IV, pick_word(), 3'($urandom));
            end else begin
                push_transaction(OP_UNUSED, pick_word(), 3'($urandom));
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_idle = 37;
        recv_idle = 69;

        push_transaction(OP_RESTORE_IV, 32'h0, 3'd7);
        push_transaction(OP_UNUSED, 32'hffffffff, 3'd7);
        push_transaction(OP_MSG_WORD, 32'hffffffff, 3'd0);
        push_transaction(OP_MSG_WORD, 32'h00000000, 3'd7);
        push_transaction(OP_MSG_WORD, 32'h12345678, 3'd3);
        push_transaction(OP_RESTORE_IV, 32'hffffffff, 3'd0);
        push_transaction(OP_MSG_WORD, 32'h61626380, 3'd0);
        for (int i = 1; i < 15; i++) begin
            push_transaction(OP_MSG_WORD, 32'h0, 3'(i));
        end
        push_transaction(OP_MSG_WORD, 32'h00000018, 3'd7);
        blocks_sent++;
        push_transaction(OP_LOAD_CHAIN, 32'h00000000, 3'd0);
        push_transaction(OP_LOAD_CHAIN, 32'hffffffff, 3'd7);

        random_phase(ITEMS_PHASE);
        send_idle = 69;
        recv_idle = 37;
        random_phase(ITEMS_PHASE);
        send_idle = 0;
        recv_idle = 0;
        random_phase(ITEMS_PHASE);

        s_valid = 1'b0;
        while (pending != 0) begin
            @(posedge aclk);
        end
        repeat (120) @(posedge aclk);

        $display("Sent %0d input transactions covering %0d full message blocks,", items_sent,
                 blocks_sent);
        $display("checked %0d digest words under three idle mixes", digests_checked);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/sbc_pkg.sv
rtl/sbc_schedule.sv
rtl/sbc_round.sv
rtl/sha256_block_compress_unit.sv
test/sha256_block_compress_checker.sv
test/sha256_block_compress_unit_tb.sv
